FILE: rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the periodic compare timer.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 32;

    // Fixed field widths of the ports
    localparam int OP_W       = 2;
    localparam int CHAN_W     = 2;
    localparam int PERIOD_W   = 31;
    localparam int CFG_DATA_W = 32;
    localparam int MASK_W     = 4;
    localparam int COUNT_OUT_W = 32;

    // Start lead rule: a lead of LeadMargin ticks or less gets LeadExtra more
    localparam logic [COUNT_WIDTH-1:0] LEAD_MARGIN = COUNT_WIDTH'(2);
    localparam logic [COUNT_WIDTH-1:0] LEAD_EXTRA  = COUNT_WIDTH'(10);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET [4] = '{
        PERIOD_W'(10), PERIOD_W'(1000), PERIOD_W'(10000), PERIOD_W'(100000)
    };

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAN_W-1:0] sel;
    } pct_item_t;

    // Input stage to core
    typedef struct packed {
        logic      valid;
        pct_item_t item;
    } pct_stage_t;

    typedef logic [NUM_CHANNELS-1:0][PERIOD_W-1:0] period_vec_t;

endpackage

FILE: rtl/pct_cfg_regs.sv
// ----------------------------------------------------------------------------
// pct_cfg_regs
// Period registers, one per channel, written over the configuration port.
// ----------------------------------------------------------------------------
module pct_cfg_regs
    import pct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CHAN_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output period_vec_t           periods
);

    period_vec_t period_reg;

    assign cfg_ready = 1'b1;
    assign periods   = period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                period_reg[c] <= PERIOD_RESET[c];
            end
        end
        else if (cfg_valid)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (cfg_index == CHAN_W'(c))
                begin
                    period_reg[c] <= cfg_data[PERIOD_W-1:0];
                end
            end
        end
    end

endmodule

FILE: rtl/pct_in_stage.sv
// ----------------------------------------------------------------------------
// pct_in_stage
// Input register: holds one accepted word until the core takes it.
// ----------------------------------------------------------------------------
module pct_in_stage
    import pct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [CHAN_W-1:0] chan_sel,
    input  logic              take,
    output pct_stage_t        stage
);

    logic      valid_reg;
    pct_item_t item_reg;

    // Free slot, or the held word leaves this cycle
    assign in_ready    = !valid_reg || take;
    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op  <= op_t'(operation);
            item_reg.sel <= chan_sel;
        end
    end

endmodule

FILE: rtl/pct_core.sv
// ----------------------------------------------------------------------------
// pct_core
// Counter, compare values and armed bits; one word processed per cycle while the result slot is empty or being emptied.
// ----------------------------------------------------------------------------
module pct_core
    import pct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pct_stage_t             stage,
    output logic                   take,
    input  period_vec_t            periods,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [MASK_W-1:0]      match_mask,
    output logic [COUNT_OUT_W-1:0] count_now,
    output logic [MASK_W-1:0]      running_mask
);

    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  cmp_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  cmp_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] armed_reg, armed_next;
    logic [NUM_CHANNELS-1:0] match_reg, match_next;
    logic                    out_valid_reg;

    logic [COUNT_WIDTH-1:0] tick_count;
    logic [PERIOD_W-1:0]    period_sel;
    logic [COUNT_WIDTH-1:0] lead;
    logic                   lead_short;
    logic [COUNT_WIDTH-1:0] start_cmp;
    logic                   sel_ok;

    // Advance when the result slot is empty or being emptied
    assign take = stage.valid && (!out_valid_reg || out_ready);

    assign out_valid    = out_valid_reg;
    assign match_mask   = MASK_W'(match_reg);
    assign running_mask = MASK_W'(armed_reg);
    assign count_now    = COUNT_OUT_W'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        cmp_next   = cmp_reg;
        armed_next = armed_reg;
        match_next = '0;

        tick_count = count_reg + 1'b1;
        sel_ok     = int'(stage.item.sel) < NUM_CHANNELS;

        period_sel = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (stage.item.sel == CHAN_W'(c))
            begin
                period_sel = periods[c];
            end
        end

        // Period is zero-extended to the counter width, so the lead is never negative; a tiny lead is pushed out
        lead       = COUNT_WIDTH'(period_sel);
        lead_short = lead[COUNT_WIDTH-1] || (lead <= LEAD_MARGIN);
        start_cmp  = count_reg + lead + (lead_short ? LEAD_EXTRA : '0);

        unique case (stage.item.op)
            OP_TICK:
            begin
                count_next = tick_count;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (armed_reg[c] && (cmp_reg[c] == tick_count))
                    begin
                        match_next[c] = 1'b1;
                        cmp_next[c]   = cmp_reg[c] + COUNT_WIDTH'(periods[c]);
                    end
                end
            end
            OP_START:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (sel_ok && (stage.item.sel == CHAN_W'(c)))
                    begin
                        cmp_next[c]   = start_cmp;
                        armed_next[c] = 1'b1;
                    end
                end
            end
            OP_STOP:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (sel_ok && (stage.item.sel == CHAN_W'(c)))
                    begin
                        armed_next[c] = 1'b0;
                    end
                end
            end
            default:
            begin
                // unknown operation: hold everything
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            armed_reg     <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                cmp_reg[c] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                armed_reg     <= armed_next;
                match_reg     <= match_next;
                out_valid_reg <= 1'b1;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    cmp_reg[c] <= cmp_next[c];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_match_only_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((match_reg & ~armed_reg) == '0))
        else $error("match reported on a stopped channel");

    a_no_match_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (stage.item.op != OP_TICK)) |=> (match_reg == '0))
        else $error("match reported on a non-tick word");

    a_count_holds_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (stage.item.op != OP_TICK)) |=> (count_reg == $past(count_reg)))
        else $error("counter moved on a non-tick word");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (stage.item.op == OP_TICK)) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("counter did not advance on a tick");

endmodule

FILE: rtl/periodic_compare_timer_top.sv
// ----------------------------------------------------------------------------
// periodic_compare_timer_top
// Four-channel periodic output-compare timer on one shared wrapping counter.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    operation, chan_sel
//  out      out_valid / out_ready  match_mask, count_now, running_mask
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (period of channel)
//
//  One word per cycle sustained while the output is not stalled; an accepted
//  word passes the input register, then the counter/compare logic into the
//  result register. Every word gives exactly one result.
//  Reset clears the counter, compare values and armed bits, and loads the
//  default periods. cfg_ready is always high.
//  A stalled output holds the result; input keeps flowing while the result
//  slot empties in the same cycle.
// ----------------------------------------------------------------------------
module periodic_compare_timer_top
    import pct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        operation,
    input  logic [CHAN_W-1:0]      chan_sel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [MASK_W-1:0]      match_mask,
    output logic [COUNT_OUT_W-1:0] count_now,
    output logic [MASK_W-1:0]      running_mask,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CHAN_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    period_vec_t periods;
    pct_stage_t  stage;
    logic        take;

    pct_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .periods   (periods)
    );

    pct_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .chan_sel  (chan_sel),
        .take      (take),
        .stage     (stage)
    );

    pct_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .periods      (periods),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_mask   (match_mask),
        .count_now    (count_now),
        .running_mask (running_mask)
    );

endmodule

FILE: dv/periodic_compare_timer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_compare_timer_top_tb
// Self-checking bench for the four-channel periodic compare timer.
// A driver feeds tick/start/stop words from a queue and predicts each result
// at accept time with its own model of counter, compare values and armed
// bits. A monitor checks every result word in order. Phases change the
// channel periods and the idle pattern of both sides.
// ----------------------------------------------------------------------------
module periodic_compare_timer_top_tb;
    import pct_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN  = 2'd3;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              PHASE_WORDS = 264;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAN_W-1:0] sel;
    } timer_word_t;

    typedef struct packed {
        logic [MASK_W-1:0]      match;
        logic [COUNT_OUT_W-1:0] count;
        logic [MASK_W-1:0]      running;
    } timer_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [OP_W-1:0]        operation = '0;
    logic [CHAN_W-1:0]      chan_sel = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [MASK_W-1:0]      match_mask;
    logic [COUNT_OUT_W-1:0] count_now;
    logic [MASK_W-1:0]      running_mask;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CHAN_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Timer model
    logic [COUNT_WIDTH-1:0] mdl_count;
    logic [COUNT_WIDTH-1:0] mdl_cmp [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] mdl_armed;
    logic [PERIOD_W-1:0]    mdl_period [NUM_CHANNELS];

    timer_word_t   pending_words [$];
    timer_result_t expected_results [$];
    int            words_queued = 0;
    int            words_accepted = 0;
    int            errors = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    periodic_compare_timer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .chan_sel     (chan_sel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_mask   (match_mask),
        .count_now    (count_now),
        .running_mask (running_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic timer_predict(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] sel);
        timer_result_t          r;
        logic [COUNT_WIDTH-1:0] cmp;
        logic [COUNT_WIDTH-1:0] lead;
        r.match = '0;
        case (op)
            OP_TICK:
            begin
                mdl_count = mdl_count + 1'b1;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (mdl_armed[c] && mdl_cmp[c] == mdl_count)
                    begin
                        r.match[c] = 1'b1;
                        mdl_cmp[c] = mdl_cmp[c] + COUNT_WIDTH'(mdl_period[c]);
                    end
                end
            end
            OP_START:
            begin
                if (int'(sel) < NUM_CHANNELS)
                begin
                    cmp  = mdl_count + COUNT_WIDTH'(mdl_period[sel]);
                    lead = cmp - mdl_count;
                    // push a short or negative lead out past the current count
                    if (lead[COUNT_WIDTH-1] || lead <= LEAD_MARGIN)
                        cmp = cmp + LEAD_EXTRA;
                    mdl_cmp[sel]   = cmp;
                    mdl_armed[sel] = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (int'(sel) < NUM_CHANNELS)
                    mdl_armed[sel] = 1'b0;
            end
            default: ;
        endcase
        r.count   = mdl_count;
        r.running = mdl_armed;
        expected_results.push_back(r);
    endtask

    // Input driver: predict on accept, hold while stalled, else issue or idle
    always @(posedge clk)
    begin
        timer_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                timer_predict(operation, chan_sel);
                words_accepted++;
            end
            if (in_valid && !in_ready)
                ;
            else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                in_valid  <= 1'b1;
                operation <= w.op;
                chan_sel  <= w.sel;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        timer_result_t e;
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result match=%h count=%h running=%h",
                         $time, match_mask, count_now, running_mask);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (match_mask !== e.match)
                begin
                    $display("%0t: match_mask expected %h actual %h", $time, e.match, match_mask);
                    errors++;
                end
                if (count_now !== e.count)
                begin
                    $display("%0t: count_now expected %h actual %h", $time, e.count, count_now);
                    errors++;
                end
                if (running_mask !== e.running)
                begin
                    $display("%0t: running_mask expected %h actual %h",
                             $time, e.running, running_mask);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[periodic_compare_timer_top] ERROR");
            $finish;
        end
    end

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] sel);
        timer_word_t w;
        w.op  = op;
        w.sel = sel;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Wait until every queued word is accepted and its result has come back
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Leave cfg_valid high between back-to-back writes; caller drops it
    task automatic period_write(input int idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= CHAN_W'(idx);
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mdl_period[idx] = data[PERIOD_W-1:0];
    endtask

    task automatic set_periods(input int kind);
        logic [CFG_DATA_W-1:0] d;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (kind == 0)
                d = {1'($urandom_range(0, 1)), PERIOD_W'($urandom_range(1, 24))};
            else
            begin
                case ($urandom_range(0, 7))
                    0: d = {1'($urandom_range(0, 1)), PERIOD_W'(0)};
                    1: d = 32'd1;
                    2: d = 32'd3;
                    3: d = 32'hFFFF_FFFF;
                    4: d = 32'h7FFF_FFFF;
                    5: d = $urandom();
                    default: d = 32'($urandom_range(2, 60));
                endcase
            end
            period_write(c, d);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_words(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                queue_word(OP_TICK, CHAN_W'($urandom_range(0, 3)));
            else if (pick < 87)
                queue_word(OP_START, CHAN_W'($urandom_range(0, 3)));
            else if (pick < 93)
                queue_word(OP_STOP, CHAN_W'($urandom_range(0, 3)));
            else
                queue_word(OP_UNKNOWN, CHAN_W'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        mdl_count = '0;
        mdl_armed = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            mdl_cmp[c]    = '0;
            mdl_period[c] = PERIOD_RESET[c];
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Default periods: unknown op, stop while stopped, start, re-arm
        send_idle_pct = 38;
        recv_idle_pct = 56;
        queue_word(OP_UNKNOWN, 2'd3);
        queue_word(OP_STOP, 2'd0);
        queue_word(OP_START, 2'd0);
        queue_word(OP_START, 2'd3);
        queue_word(OP_TICK, 2'd2);
        queue_word(OP_STOP, 2'd3);
        queue_word(OP_START, 2'd0);
        wait_drained();

        // Short leads on periods 1 and 2, no extra on 3, zero period on channel 3
        period_write(0, 32'd1);
        period_write(1, 32'd2);
        period_write(2, 32'd3);
        period_write(3, 32'h8000_0000);
        cfg_valid <= 1'b0;
        @(posedge clk);
        for (int c = 0; c < NUM_CHANNELS; c++)
            queue_word(OP_START, CHAN_W'(c));
        for (int i = 0; i < 13; i++)
            queue_word(OP_TICK, CHAN_W'(i));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 56;
            end
            else if (p < 4)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_periods(p % 2);
            @(posedge clk);
            queue_random_words(PHASE_WORDS / 2);
            // hold the sender until everything in flight has returned
            wait_drained();
            queue_random_words(PHASE_WORDS / 2);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[periodic_compare_timer_top] OK");
        else
            $display("[periodic_compare_timer_top] ERROR");
        $finish;
    end

endmodule
